// ----- hw/rtl/smap_pkg.sv -----
// shared types and constants for the stun mapped address parser
package smap_pkg;

  localparam int MAX_PACKET = 2048;
  localparam int POS_W      = $clog2(MAX_PACKET + 1);
  localparam int OFF_W      = 18;
  localparam int END_W      = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 64;

  localparam logic [31:0]      COOKIE          = 32'h2112A442;
  localparam logic [15:0]      TYPE_RESPONSE   = 16'h0101;
  localparam logic [15:0]      ATTR_XOR_MAPPED = 16'h0020;
  localparam logic [15:0]      ATTR_MAPPED     = 16'h0001;
  localparam logic [7:0]       FAMILY_IPV4     = 8'h01;
  localparam logic [OFF_W-1:0] HEADER_BYTES    = OFF_W'(20);
  localparam logic [15:0]      MIN_ADDR_LEN    = 16'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_TXID_UPPER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TXID_LOWER = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        mapped_found;
    logic [31:0] mapped_address;
    logic [15:0] mapped_port;
  } out_item_t;

  typedef struct packed {
    logic [31:0] upper;
    logic [63:0] lower;
  } txid_t;

endpackage

// ----- hw/rtl/smap_cfg_regs.sv -----
// transaction id registers written through the config port
module smap_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [smap_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [smap_pkg::CFG_DATA_W-1:0] cfg_data,
  output smap_pkg::txid_t                 txid
);
  import smap_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      txid <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TXID_UPPER: txid.upper <= cfg_data[31:0];
        CFG_TXID_LOWER: txid.lower <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/smap_in_reg.sv -----
// input register stage for received bytes
module smap_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  smap_pkg::in_item_t in_data,
  output logic               q_valid,
  output smap_pkg::in_item_t q_data,
  input  logic               q_take
);
  import smap_pkg::*;

  assign in_ready = !q_valid || q_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_data <= in_data;
    end
  end

endmodule

// ----- hw/rtl/smap_parser.sv -----
// header check, attribute walk, result forming; one byte per cycle, stalls aside
module smap_parser (
  input  logic                clk,
  input  logic                rst,
  input  smap_pkg::txid_t     txid,
  input  logic                q_valid,
  input  smap_pkg::in_item_t  q_data,
  output logic                q_take,
  input  logic                res_space,
  output logic                res_valid,
  output smap_pkg::out_item_t res_data
);
  import smap_pkg::*;

  logic [POS_W-1:0] pos, pos_next;
  logic             hg, hg_next;
  logic [END_W-1:0] dend, dend_next;
  logic [OFF_W-1:0] ns, ns_next;
  logic [15:0]      atype, atype_next;
  logic [15:0]      alen, alen_next;
  logic             dec, dec_next;
  logic             good, good_next;
  logic [31:0]      gather, gather_next;
  logic [15:0]      cport, cport_next;
  logic [31:0]      caddr, caddr_next;

  logic [127:0]     hdr_vec;
  logic [3:0]       hdr_idx;
  logic [7:0]       exp_byte;
  logic [7:0]       b;
  logic [OFF_W-1:0] ix;
  logic [OFF_W-1:0] dend_x;
  logic [OFF_W-1:0] len_round;
  logic [31:0]      word;
  logic [2:0]       k;
  logic             active;
  logic             found;

  assign b        = q_data.data_byte;
  assign q_take   = q_valid && (!q_data.last_byte || res_space);
  assign res_valid = q_valid && q_data.last_byte && res_space;
  assign active   = pos < POS_W'(MAX_PACKET);
  assign ix       = OFF_W'(pos);
  assign dend_x   = OFF_W'(dend);
  // bytes 4 to 19 of the header as one word, byte 4 on top
  assign hdr_vec  = {COOKIE, txid.upper, txid.lower};
  assign hdr_idx  = 4'(5'd19 - pos[4:0]);
  assign exp_byte = hdr_vec[{hdr_idx, 3'b000} +: 8];
  assign word     = {gather[23:0], b};
  assign len_round = (OFF_W'(word[15:0]) + OFF_W'(3)) & ~OFF_W'(3);
  assign k        = 3'(ix - ns);

  always_comb begin
    pos_next    = pos;
    hg_next     = hg;
    dend_next   = dend;
    ns_next     = ns;
    atype_next  = atype;
    alen_next   = alen;
    dec_next    = dec;
    good_next   = good;
    gather_next = gather;
    cport_next  = cport;
    caddr_next  = caddr;
    if (q_take && active) begin
      pos_next = pos + POS_W'(1);
      if (ix < HEADER_BYTES) begin
        if (pos < POS_W'(4)) begin
          gather_next = word;
          if (pos == POS_W'(1) && word[15:0] != TYPE_RESPONSE) begin
            hg_next = 1'b0;
          end
          if (pos == POS_W'(3)) begin
            dend_next = END_W'(HEADER_BYTES) + END_W'(word[15:0]);
          end
        end else if (b != exp_byte) begin
          hg_next = 1'b0;
        end
      end else if (!dec) begin
        // attribute header bytes, only while the header fits the declared length
        if (!(ns + OFF_W'(4) > dend_x) && ix >= ns && ix < ns + OFF_W'(4)) begin
          gather_next = word;
          if (ix == ns + OFF_W'(3)) begin
            if (word[31:16] == ATTR_XOR_MAPPED || word[31:16] == ATTR_MAPPED) begin
              dec_next   = 1'b1;
              atype_next = word[31:16];
              alen_next  = word[15:0];
              ns_next    = ns + OFF_W'(4);
            end else begin
              ns_next = ns + OFF_W'(4) + len_round;
            end
          end
        end
      end else if (ix >= ns && ix < ns + OFF_W'(8)) begin
        case (k)
          3'd0: ;
          3'd1: good_next = (b == FAMILY_IPV4);
          3'd2, 3'd3: cport_next = {cport[7:0], b};
          default: caddr_next = {caddr[23:0], b};
        endcase
      end
    end

    found = hg_next && (OFF_W'(pos_next) >= HEADER_BYTES) && dec_next && good_next &&
            (alen_next >= MIN_ADDR_LEN) &&
            (OFF_W'(pos_next) >= ns_next + OFF_W'(alen_next));
    res_data = '0;
    if (found) begin
      res_data.mapped_found   = 1'b1;
      res_data.mapped_address = caddr_next;
      res_data.mapped_port    = cport_next;
      if (atype_next == ATTR_XOR_MAPPED) begin
        res_data.mapped_address = caddr_next ^ COOKIE;
        res_data.mapped_port    = cport_next ^ COOKIE[31:16];
      end
    end

    // datagram done: back to the idle parse state
    if (res_valid) begin
      pos_next  = '0;
      hg_next   = 1'b1;
      dend_next = '0;
      ns_next   = HEADER_BYTES;
      dec_next  = 1'b0;
      good_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      hg   <= 1'b1;
      dend <= '0;
      ns   <= HEADER_BYTES;
      dec  <= 1'b0;
      good <= 1'b0;
    end else begin
      pos  <= pos_next;
      hg   <= hg_next;
      dend <= dend_next;
      ns   <= ns_next;
      dec  <= dec_next;
      good <= good_next;
    end
  end

  always_ff @(posedge clk) begin
    atype  <= atype_next;
    alen   <= alen_next;
    gather <= gather_next;
    cport  <= cport_next;
    caddr  <= caddr_next;
  end

endmodule

// ----- hw/rtl/smap_out_reg.sv -----
// result register toward the output channel
module smap_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                res_valid,
  input  smap_pkg::out_item_t res_data,
  output logic                res_space,
  output logic                out_valid,
  input  logic                out_ready,
  output smap_pkg::out_item_t out_data
);
  import smap_pkg::*;

  assign res_space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_space) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_space) begin
      out_data <= res_data;
    end
  end

endmodule

// ----- hw/rtl/stun_mapped_address_parser_top.sv -----
// top level of the stun binding response mapped address parser
//
//   channel  | handshake             | payload
//   in       | in_valid / in_ready   | in_data: data_byte, last_byte
//   out      | out_valid / out_ready | out_data: mapped_found, mapped_address, mapped_port
//   cfg      | cfg_write             | cfg_index, cfg_data
//
// one byte per cycle while the output takes results: a byte is held in the input register and is parsed there
// the result of a datagram is written to the output register when its last beat is taken from the input register
// the parse state is one register set updated per byte, which sets the rate
// reset clears the transaction id and parse state; no clearing pass
// a stalled output holds only a last byte; other bytes keep flowing
module stun_mapped_address_parser_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  smap_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output smap_pkg::out_item_t             out_data,
  input  logic                            cfg_write,
  input  logic [smap_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [smap_pkg::CFG_DATA_W-1:0] cfg_data
);
  import smap_pkg::*;

  txid_t     txid;
  logic      q_valid;
  in_item_t  q_data;
  logic      q_take;
  logic      res_space;
  logic      res_valid;
  out_item_t res_data;

  smap_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .txid      (txid)
  );

  smap_in_reg u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_take   (q_take)
  );

  smap_parser u_parse (
    .clk       (clk),
    .rst       (rst),
    .txid      (txid),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_take    (q_take),
    .res_space (res_space),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  smap_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_space (res_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
